/* design/vpw_pkg.sv */
`timescale 1ns / 1ps

package vpw_pkg;

    // Data widths fixed by the interface.
    localparam int Q_W    = 32;
    localparam int VP_W   = 16;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 2;
    localparam int WIDE_W = 2 * Q_W + 2;

    // Default configuration of the top level.
    localparam int DEFAULT_FRAC_BITS   = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Command codes.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // Matrix select codes.
    localparam logic MAT_MODELVIEW  = 1'b0;
    localparam logic MAT_PROJECTION = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_W-1:0] CFG_WIDTH    = 2'd2;
    localparam logic [CFG_W-1:0] CFG_HEIGHT   = 2'd3;

    // One classified input item as it sits in the queue.
    typedef struct packed {
        logic                    is_load;
        logic                    mat_sel;
        logic [IDX_W-1:0]        idx;
        logic signed [Q_W-1:0]   value;
        logic signed [Q_W-1:0]   px;
        logic signed [Q_W-1:0]   py;
        logic signed [Q_W-1:0]   pz;
    } vpw_item_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        vpw_item_t item;
    } vpw_head_t;

    // Viewport registers.
    typedef struct packed {
        logic signed [VP_W-1:0] origin_x;
        logic signed [VP_W-1:0] origin_y;
        logic [VP_W-1:0]        width;
        logic [VP_W-1:0]        height;
    } vpw_viewport_t;

    // Saturate a wide signed value to the Q range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > WIDE_W'(Q_MAX))
            r = Q_MAX;
        else if (v < WIDE_W'(Q_MIN))
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

/* design/vpw_front.sv */
`timescale 1ns / 1ps

module vpw_front #(
    parameter int DEPTH = vpw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic                            matrix_select,
    input  logic [vpw_pkg::IDX_W-1:0]       entry_index,
    input  logic signed [vpw_pkg::Q_W-1:0]  entry_value,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_x,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_y,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_z,
    output vpw_pkg::vpw_head_t              head,
    input  logic                            pop
);
    import vpw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vpw_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    vpw_item_t        item;
    logic             push;

    // Classify the incoming beat.
    always_comb
    begin
        item.is_load = (cmd == CMD_LOAD);
        item.mat_sel = matrix_select;
        item.idx     = entry_index;
        item.value   = entry_value;
        item.px      = point_x;
        item.py      = point_y;
        item.pz      = point_z;
    end

    assign in_stall = (count_reg == CNT_W'(DEPTH));
    assign push     = in_valid && !in_stall;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        if (push)
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= item;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rptr_reg];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds its depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue did not grow on a push without a pop");
`endif

endmodule

/* design/vpw_div_lane.sv */
`timescale 1ns / 1ps

module vpw_div_lane #(
    parameter int FRAC_BITS = vpw_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [vpw_pkg::Q_W-1:0] num,
    input  logic signed [vpw_pkg::Q_W-1:0] den,
    output logic signed [vpw_pkg::Q_W-1:0] quot
);
    import vpw_pkg::*;

    localparam int N = Q_W + FRAC_BITS;

    logic [Q_W-1:0]        rem_reg [0:N];
    logic [N-1:0]          dvd_reg [0:N];
    logic [N-1:0]          quo_reg [0:N];
    logic [Q_W-1:0]        den_reg [0:N];
    logic                  neg_reg [0:N];
    logic signed [Q_W-1:0] quot_reg;
    logic [Q_W-1:0]        num_mag;
    logic [Q_W-1:0]        den_mag;
    logic [N-1:0]          q;
    logic [Q_W-1:0]        q_neg;
    logic                  pos_ovf;
    logic                  neg_ovf;

    // Operand magnitudes; the quotient sign is applied at the end.
    assign num_mag = num[Q_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[Q_W-1] ? (~den + 1'b1) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            dvd_reg[0] <= N'(num_mag) << FRAC_BITS;
            quo_reg[0] <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= num[Q_W-1] ^ den[Q_W-1];
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [Q_W:0] trial;
        logic [Q_W:0] diff;
        logic         ge;

        assign trial = {rem_reg[k], dvd_reg[k][N-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
                dvd_reg[k+1] <= dvd_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][N-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Sign and saturation of the quotient.
    assign q       = quo_reg[N];
    assign q_neg   = ~q[Q_W-1:0] + 1'b1;
    assign pos_ovf = |q[N-1:Q_W-1];
    assign neg_ovf = (|q[N-1:Q_W]) || (q[Q_W-1] && (|q[Q_W-2:0]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[N])
                quot_reg <= neg_ovf ? Q_MIN : $signed(q_neg);
            else
                quot_reg <= pos_ovf ? Q_MAX : $signed(q[Q_W-1:0]);
        end
    end

    assign quot = quot_reg;

endmodule

/* design/vpw_back.sv */
`timescale 1ns / 1ps

module vpw_back #(
    parameter int FRAC_BITS = vpw_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vpw_pkg::vpw_head_t             head,
    output logic                           pop,
    input  vpw_pkg::vpw_viewport_t         vp,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           projected_ok,
    output logic signed [vpw_pkg::Q_W-1:0] window_x,
    output logic signed [vpw_pkg::Q_W-1:0] window_y,
    output logic signed [vpw_pkg::Q_W-1:0] window_depth
);
    import vpw_pkg::*;

    localparam int DIV_LAT = Q_W + FRAC_BITS + 2;
    localparam int SPAN_W  = Q_W + VP_W + 2;
    localparam logic signed [Q_W-1:0]    ONE  = Q_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

    logic                      adv;
    logic signed [Q_W-1:0]     mv_reg [16];
    logic signed [Q_W-1:0]     pj_reg [16];
    logic signed [Q_W-1:0]     obj [4];

    logic signed [2*Q_W-1:0]   p1_reg [4][4];
    logic signed [2*Q_W-1:0]   p3_reg [4][4];
    logic signed [Q_W-1:0]     eye2_reg [4];
    logic signed [Q_W-1:0]     clip4_reg [4];
    logic signed [Q_W-1:0]     eye_next [4];
    logic signed [Q_W-1:0]     clip_next [4];

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic                      ld1_reg, ld2_reg;
    logic [IDX_W-1:0]          ld1_idx_reg, ld2_idx_reg;
    logic signed [Q_W-1:0]     ld1_val_reg, ld2_val_reg;

    logic                      vld_pipe_reg [1:DIV_LAT];
    logic                      wz_pipe_reg [1:DIV_LAT];
    logic signed [Q_W-1:0]     ndc [3];

    logic                      vw_reg, okw_reg;
    logic signed [SPAN_W-1:0]  spx_reg, spy_reg;
    logic signed [Q_W-1:0]     dep_reg;
    logic signed [Q_W:0]       sx, sy, sz;
    logic signed [VP_W:0]      wid, hgt;

    logic                      out_valid_reg;
    logic                      ok_reg;
    logic signed [Q_W-1:0]     x_reg, y_reg, d_reg;
    logic signed [Q_W-1:0]     x_next, y_next;

    // The whole pipeline moves whenever the output register can take a beat.
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && head.valid;

    // Model-view entries are written as the load leaves the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    mv_reg[c*4+r] <= (c == r) ? ONE : '0;
        end
        else if (pop && head.item.is_load && head.item.mat_sel == MAT_MODELVIEW)
            mv_reg[head.item.idx] <= head.item.value;
    end

    // Projection entries are written where projects read them, keeping order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    pj_reg[c*4+r] <= (c == r) ? ONE : '0;
        end
        else if (adv && ld2_reg)
            pj_reg[ld2_idx_reg] <= ld2_val_reg;
    end

    assign obj[0] = head.item.px;
    assign obj[1] = head.item.py;
    assign obj[2] = head.item.pz;
    assign obj[3] = ONE;

    // Control bits of the matrix stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ld1_reg <= 1'b0;
            ld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= pop && !head.item.is_load;
            ld1_reg <= pop && head.item.is_load && head.item.mat_sel == MAT_PROJECTION;
            v2_reg  <= v1_reg;
            ld2_reg <= ld1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
        end
    end

    // Row sums with round half up, then saturation.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            eye_next[r]  = sat_q((WIDE_W'(p1_reg[r][0]) + WIDE_W'(p1_reg[r][1])
                                 + WIDE_W'(p1_reg[r][2]) + WIDE_W'(p1_reg[r][3])
                                 + HALF) >>> FRAC_BITS);
            clip_next[r] = sat_q((WIDE_W'(p3_reg[r][0]) + WIDE_W'(p3_reg[r][1])
                                 + WIDE_W'(p3_reg[r][2]) + WIDE_W'(p3_reg[r][3])
                                 + HALF) >>> FRAC_BITS);
        end
    end

    // Matrix products and sums: eye, then clip coordinates.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    p1_reg[r][c] <= mv_reg[c*4+r] * obj[c];
                    p3_reg[r][c] <= pj_reg[c*4+r] * eye2_reg[c];
                end
                eye2_reg[r]  <= eye_next[r];
                clip4_reg[r] <= clip_next[r];
            end
            ld1_idx_reg <= head.item.idx;
            ld1_val_reg <= head.item.value;
            ld2_idx_reg <= ld1_idx_reg;
            ld2_val_reg <= ld1_val_reg;
        end
    end

    // Perspective divide, one lane for each of x, y and z.
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vpw_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (adv),
            .num  (clip4_reg[i]),
            .den  (clip4_reg[3]),
            .quot (ndc[i])
        );
    end

    // Valid and zero-w flags travel beside the divider lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= DIV_LAT; k++)
                vld_pipe_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_pipe_reg[1] <= v4_reg;
            for (int k = 2; k <= DIV_LAT; k++)
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wz_pipe_reg[1] <= (clip4_reg[3] == '0);
            for (int k = 2; k <= DIV_LAT; k++)
                wz_pipe_reg[k] <= wz_pipe_reg[k-1];
        end
    end

    // Viewport spans and depth.
    assign sx  = (Q_W+1)'(ONE) + (Q_W+1)'(ndc[0]);
    assign sy  = (Q_W+1)'(ONE) + (Q_W+1)'(ndc[1]);
    assign sz  = (Q_W+1)'(ONE) + (Q_W+1)'(ndc[2]);
    assign wid = $signed({1'b0, vp.width});
    assign hgt = $signed({1'b0, vp.height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vw_reg <= 1'b0;
        else if (adv)
            vw_reg <= vld_pipe_reg[DIV_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            okw_reg <= !wz_pipe_reg[DIV_LAT];
            spx_reg <= sx * wid;
            spy_reg <= sy * hgt;
            dep_reg <= sat_q(WIDE_W'(sz >>> 1));
        end
    end

    // Window offset plus half span.
    assign x_next = sat_q((WIDE_W'(vp.origin_x) <<< FRAC_BITS) + WIDE_W'(spx_reg >>> 1));
    assign y_next = sat_q((WIDE_W'(vp.origin_y) <<< FRAC_BITS) + WIDE_W'(spy_reg >>> 1));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vw_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg <= okw_reg;
            x_reg  <= okw_reg ? x_next  : '0;
            y_reg  <= okw_reg ? y_next  : '0;
            d_reg  <= okw_reg ? dep_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign projected_ok = ok_reg;
    assign window_x     = x_reg;
    assign window_y     = y_reg;
    assign window_depth = d_reg;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (x_reg == '0 && y_reg == '0 && d_reg == '0))
        else $error("failed projection carries nonzero coordinates");

    a_stage_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(ld2_reg && v2_reg))
        else $error("load and project share a pipeline stage");
`endif

endmodule

/* design/vertex_project_to_window.sv */
`timescale 1ns / 1ps
// Values are signed fixed point, Q16.16 at the default FRAC_BITS.
// Throughput: one item per cycle; the divider lanes are fully pipelined, one quotient bit
// per stage, and a stalled output holds the whole back end while the queue fills up.
// Load items give no result; projection loads travel the matrix stages in order with projects.
// Reset (rst_n low, asynchronous) loads both matrices with identity, clears the viewport
// registers to zero and empties the queue and pipeline.

module vertex_project_to_window #(
    parameter int FRAC_BITS   = vpw_pkg::DEFAULT_FRAC_BITS,
    parameter int QUEUE_DEPTH = vpw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic                            matrix_select,
    input  logic [vpw_pkg::IDX_W-1:0]       entry_index,
    input  logic signed [vpw_pkg::Q_W-1:0]  entry_value,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_x,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_y,
    input  logic signed [vpw_pkg::Q_W-1:0]  point_z,
    input  logic                            cfg_we,
    input  logic [vpw_pkg::CFG_W-1:0]       cfg_index,
    input  logic [vpw_pkg::VP_W-1:0]        cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            projected_ok,
    output logic signed [vpw_pkg::Q_W-1:0]  window_x,
    output logic signed [vpw_pkg::Q_W-1:0]  window_y,
    output logic signed [vpw_pkg::Q_W-1:0]  window_depth
);
    import vpw_pkg::*;

    vpw_viewport_t vp_reg;
    vpw_head_t     head;
    logic          pop;

    // Viewport registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: vp_reg.origin_x <= $signed(cfg_wdata);
                CFG_ORIGIN_Y: vp_reg.origin_y <= $signed(cfg_wdata);
                CFG_WIDTH:    vp_reg.width    <= cfg_wdata;
                CFG_HEIGHT:   vp_reg.height   <= cfg_wdata;
                default:      vp_reg          <= vp_reg;
            endcase
        end
    end

    vpw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .matrix_select (matrix_select),
        .entry_index   (entry_index),
        .entry_value   (entry_value),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .head          (head),
        .pop           (pop)
    );

    vpw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .vp           (vp_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .projected_ok (projected_ok),
        .window_x     (window_x),
        .window_y     (window_y),
        .window_depth (window_depth)
    );

endmodule

/* sim/tb_vertex_project_to_window.sv */
`timescale 1ns / 1ps

module tb_vertex_project_to_window;
    import vpw_pkg::*;

    localparam int  FRAC      = DEFAULT_FRAC_BITS;
    localparam int  DRAIN_CYC = 120;
    localparam int  WD_LIMIT  = 6000;
    localparam longint ONE    = longint'(1) << FRAC;

    typedef struct {
        logic                  ok;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] depth;
    } window_pt_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   cmd = CMD_LOAD;
    logic                   matrix_select = MAT_MODELVIEW;
    logic [IDX_W-1:0]       entry_index = '0;
    logic signed [Q_W-1:0]  entry_value = '0;
    logic signed [Q_W-1:0]  point_x = '0;
    logic signed [Q_W-1:0]  point_y = '0;
    logic signed [Q_W-1:0]  point_z = '0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_index = '0;
    logic [VP_W-1:0]        cfg_wdata = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   projected_ok;
    logic signed [Q_W-1:0]  window_x;
    logic signed [Q_W-1:0]  window_y;
    logic signed [Q_W-1:0]  window_depth;

    // Shadow copy of the block state used for prediction.
    logic signed [Q_W-1:0]  mv_mat [16];
    logic signed [Q_W-1:0]  pj_mat [16];
    logic signed [VP_W-1:0] vp_ox;
    logic signed [VP_W-1:0] vp_oy;
    logic [VP_W-1:0]        vp_w;
    logic [VP_W-1:0]        vp_h;

    window_pt_t projected_q [$];
    int errors = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int idle_cycles = 0;

    vertex_project_to_window DUT (.*);

    always #4 clk = ~clk;

    function automatic longint sat32(input longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    // One matrix row times a vector: exact sum of high parts and low parts,
    // rounded half up at the binary point, then saturated.
    function automatic longint row_dot(input logic use_pj, input int r,
                                       input longint v0, input longint v1,
                                       input longint v2, input longint v3);
        longint vec [4];
        longint hi;
        longint lo;
        longint p;
        longint m;
        vec[0] = v0; vec[1] = v1; vec[2] = v2; vec[3] = v3;
        hi = 0;
        lo = 0;
        for (int c = 0; c < 4; c++)
        begin
            m = use_pj ? longint'(pj_mat[c*4+r]) : longint'(mv_mat[c*4+r]);
            p = m * vec[c];
            hi += p >>> FRAC;
            lo += p & (ONE - 1);
        end
        lo += ONE >>> 1;
        return sat32(hi + (lo >>> FRAC));
    endfunction

    function automatic longint map_to_window(input logic signed [VP_W-1:0] origin,
                                             input logic [VP_W-1:0] size, input longint ndc);
        longint base;
        longint span;
        base = longint'(origin) * ONE;
        span = (ONE + ndc) * longint'(size);
        return sat32(base + (span >>> 1));
    endfunction

    // Expected window point for object point (x, y, z, 1).
    function automatic window_pt_t project_point(input logic signed [Q_W-1:0] px,
                                                 input logic signed [Q_W-1:0] py,
                                                 input logic signed [Q_W-1:0] pz);
        window_pt_t res;
        longint eye [4];
        longint clp [4];
        longint nx;
        longint ny;
        longint nz;
        for (int r = 0; r < 4; r++)
            eye[r] = row_dot(1'b0, r, longint'(px), longint'(py), longint'(pz), ONE);
        for (int r = 0; r < 4; r++)
            clp[r] = row_dot(1'b1, r, eye[0], eye[1], eye[2], eye[3]);
        res.ok = 1'b0; res.x = '0; res.y = '0; res.depth = '0;
        if (clp[3] != 0)
        begin
            nx = sat32((clp[0] * ONE) / clp[3]);
            ny = sat32((clp[1] * ONE) / clp[3]);
            nz = sat32((clp[2] * ONE) / clp[3]);
            res.ok    = 1'b1;
            res.x     = Q_W'(map_to_window(vp_ox, vp_w, nx));
            res.y     = Q_W'(map_to_window(vp_oy, vp_h, ny));
            res.depth = Q_W'(sat32((ONE + nz) >>> 1));
        end
        return res;
    endfunction

    // Send one beat; shadow state is updated at the edge where it is taken.
    task automatic send_beat(input logic c, input logic sel, input logic [IDX_W-1:0] idx,
                             input logic signed [Q_W-1:0] val, input logic signed [Q_W-1:0] px,
                             input logic signed [Q_W-1:0] py, input logic signed [Q_W-1:0] pz);
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        matrix_select <= sel;
        entry_index   <= idx;
        entry_value   <= val;
        point_x       <= px;
        point_y       <= py;
        point_z       <= pz;
        do
            @(posedge clk);
        while (in_stall);
        if (c == CMD_LOAD)
        begin
            if (sel == MAT_PROJECTION)
                pj_mat[idx] = val;
            else
                mv_mat[idx] = val;
        end
        else
            projected_q.insert(projected_q.size(), project_point(px, py, pz));
    endtask

    task automatic load_entry(input logic sel, input int idx, input logic signed [Q_W-1:0] val);
        send_beat(CMD_LOAD, sel, IDX_W'(idx), val, Q_W'($urandom), Q_W'($urandom),
                  Q_W'($urandom));
    endtask

    task automatic project(input logic signed [Q_W-1:0] px, input logic signed [Q_W-1:0] py,
                           input logic signed [Q_W-1:0] pz);
        send_beat(CMD_PROJECT, 1'($urandom), IDX_W'($urandom), Q_W'($urandom), px, py, pz);
    endtask

    // Wait until every expected point is back and the load path has drained.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (projected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Write enable is left high so writes can follow back to back.
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [VP_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_ORIGIN_X: vp_ox = data;
            CFG_ORIGIN_Y: vp_oy = data;
            CFG_WIDTH:    vp_w  = data;
            default:      vp_h  = data;
        endcase
    endtask

    task automatic set_viewport(input logic [VP_W-1:0] ox, input logic [VP_W-1:0] oy,
                                input logic [VP_W-1:0] w, input logic [VP_W-1:0] h);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // Mostly values within a few units, sometimes anything at all.
    function automatic logic signed [Q_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0, 1:    return Q_W'($urandom);
            2:       return '0;
            3:       return Q_W'(ONE);
            default: return Q_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    // Directed: identity with a zero viewport, field extremes, a perspective
    // setup, and a projection whose bottom row gives zero clip w.
    task automatic test_directed();
        project('0, '0, '0);
        project(Q_MAX, Q_MIN, Q_MAX);
        project(Q_MIN, Q_MAX, Q_MIN);
        wait_idle();
        set_viewport(16'h8000, 16'h7FFF, 16'hFFFF, 16'd0);
        project(Q_W'(ONE), Q_W'(-ONE), Q_W'(ONE >>> 1));
        project(Q_MAX, Q_MAX, Q_MAX);
        load_entry(MAT_PROJECTION, 11, Q_W'(-ONE));
        load_entry(MAT_PROJECTION, 15, '0);
        project(Q_W'(3 * ONE), Q_W'(ONE), Q_W'(-2 * ONE));
        project(Q_W'(ONE), Q_W'(ONE), Q_W'(ONE));
        load_entry(MAT_MODELVIEW, 14, Q_MIN);
        load_entry(MAT_MODELVIEW, 0, Q_MAX);
        project(Q_W'(ONE), '0, '0);
        load_entry(MAT_PROJECTION, 11, '0);
        project(Q_W'(ONE), Q_W'(ONE), Q_W'(ONE));
        project(Q_MIN, Q_MIN, Q_MIN);
        wait_idle();
        for (int i = 0; i < 16; i++)
        begin
            load_entry(MAT_MODELVIEW, i, (i % 5 == 0) ? Q_W'(ONE) : '0);
            load_entry(MAT_PROJECTION, i, (i % 5 == 0) ? Q_W'(ONE) : '0);
        end
        wait_idle();
        set_viewport(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
        project(Q_W'(-ONE), Q_W'(ONE), Q_W'(-ONE));
        project(Q_W'(ONE >>> 3), Q_W'(-ONE >>> 3), '1);
        wait_idle();
    endtask

    // Random: mostly points through random matrices, some single entry
    // loads, and now and then a whole matrix row reloaded.
    task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
        int k;
        logic sel;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            sel = 1'($urandom);
            if (k < 5)
            begin
                k = $urandom_range(0, 3);
                for (int c = 0; c < 4; c++)
                    load_entry(sel, c * 4 + k, ($urandom_range(0, 2) == 0) ? '0 : rand_q());
            end
            else if (k < 20)
                load_entry(sel, $urandom_range(0, 15), rand_q());
            else
                project(rand_q(), rand_q(), rand_q());
            // Halfway through, hold off until every result is back.
            if (i == n / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    // Result checker and output stall generator.
    always @(posedge clk)
    begin
        window_pt_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (projected_q.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                e = projected_q.pop_front();
                if (projected_ok !== e.ok)
                begin
                    $error("projected_ok: expected %0d, got %0d", e.ok, projected_ok);
                    errors++;
                end
                if (window_x !== e.x)
                begin
                    $error("window_x: expected %0d, got %0d", e.x, window_x);
                    errors++;
                end
                if (window_y !== e.y)
                begin
                    $error("window_y: expected %0d, got %0d", e.y, window_y);
                    errors++;
                end
                if (window_depth !== e.depth)
                begin
                    $error("window_depth: expected %0d, got %0d", e.depth, window_depth);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("tb_vertex_project_to_window: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            mv_mat[i] = (i % 5 == 0) ? Q_W'(ONE) : '0;
            pj_mat[i] = (i % 5 == 0) ? Q_W'(ONE) : '0;
        end
        vp_ox = '0; vp_oy = '0; vp_w = '0; vp_h = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_viewport(16'd0, 16'd0, 16'd640, 16'd480);
        test_random(290, 36, 51);
        set_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        test_random(290, 51, 36);
        set_viewport(16'hFFF0, 16'd20, 16'd1920, 16'd1080);
        test_random(290, 0, 0);
        if (errors == 0 && projected_q.size() == 0)
            $display("tb_vertex_project_to_window: clean");
        else
            $display("tb_vertex_project_to_window: errors");
        $finish;
    end

endmodule
